FILE: hw/rtl/dar_pkg.sv
// Shared constants and types for the device alias table.
package dar_pkg;

   localparam int SLOT_COUNT = 256;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int CNT_W      = SLOT_W + 1;
   localparam int KEY_W      = 48;
   localparam int TAG_W      = 16;
   localparam int ENTRY_W    = KEY_W + TAG_W;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 8;
   localparam int QUERY_W    = 16;
   localparam int VID_W      = 16;
   localparam int PID_W      = 16;
   localparam int BUS_W      = 8;
   localparam int PORT_W     = 8;

   localparam logic [TAG_W-1:0] GEN_RESET = TAG_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER = 2'd0,
      OP_SWEEP    = 2'd1,
      OP_LOOKUP   = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_LREAD,
      S_LEVAL,
      S_DONE
   } state_type;

endpackage

FILE: hw/rtl/dar_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module dar_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/device_alias_table.sv
// Device alias table: slot RAM, scan sequencer and result register.
// A full register or end-of-pass scan loads its result after one RAM read per slot, each behind
// a registered read; a register that finds its key early ends sooner. A lookup reads and then
// evaluates its slot; an out-of-range lookup and the unused operation skip to completion, where
// any output stall holds the result. A new transaction is taken only once the result is loaded.
// Reset clears the per-slot valid bits and sets the generation to one; no clear pass.
module device_alias_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [dar_pkg::OP_W-1:0]        req_operation,
   input  logic [dar_pkg::VID_W-1:0]       req_vendor_id,
   input  logic [dar_pkg::PID_W-1:0]       req_product_id,
   input  logic [dar_pkg::BUS_W-1:0]       req_bus_number,
   input  logic [dar_pkg::PORT_W-1:0]      req_port_address,
   input  logic [dar_pkg::QUERY_W-1:0]     req_slot_query,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dar_pkg::STATUS_W-1:0]    rsp_status,
   output logic [dar_pkg::SLOT_OUT_W-1:0]  rsp_slot_number,
   output logic [dar_pkg::KEY_W-1:0]       rsp_device_key
);
   import dar_pkg::*;

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic [KEY_W-1:0]         key_ff, key_in;
   logic [SLOT_W-1:0]        query_ff, query_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     rd_pend_ff, rd_pend_in;
   logic [SLOT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                     vld_rd_ff, vld_rd_in;
   logic                     have_free_ff, have_free_in;
   logic [SLOT_W-1:0]        free_idx_ff, free_idx_in;
   logic [TAG_W-1:0]         gen_ff, gen_in;
   logic [SLOT_COUNT-1:0]    valid_ff, valid_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic [SLOT_W-1:0]        res_slot_ff, res_slot_in;
   logic [KEY_W-1:0]         res_key_ff, res_key_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [KEY_W-1:0]         rsp_key_ff, rsp_key_in;

   logic                     req_accept;
   logic                     in_range;
   logic                     out_free;
   logic                     ram_wr_en;
   logic [SLOT_W-1:0]        ram_wr_addr;
   logic [ENTRY_W-1:0]       ram_wr_data;
   logic                     ram_rd_en;
   logic [SLOT_W-1:0]        ram_rd_addr;
   logic [ENTRY_W-1:0]       ram_rd_data;
   logic                     issue;
   logic [ENTRY_W-1:0]       ent_data;
   logic [KEY_W-1:0]         ent_key;
   logic [TAG_W-1:0]         ent_tag;
   logic                     last_rd;
   logic                     is_free;
   logic                     is_match;
   logic                     scan_end;

   dar_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign in_range   = (req_slot_query < QUERY_W'(SLOT_COUNT));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // A slot whose valid bit is clear reads as an all-zero entry.
   always_comb begin
      ent_data = vld_rd_ff ? ram_rd_data : '0;
      ent_key  = ent_data[KEY_W-1:0];
      ent_tag  = ent_data[ENTRY_W-1:KEY_W];
      last_rd  = rd_pend_ff && (rd_idx_ff == SLOT_W'(SLOT_COUNT - 1));
      is_free  = rd_pend_ff && (ent_key == '0) && !have_free_ff;
      is_match = rd_pend_ff && !is_free && (ent_key == key_ff);
      scan_end = (op_ff == OP_REGISTER) ? (is_match || last_rd) : last_rd;
      issue    = (state_ff == S_SCAN) && (cnt_ff != CNT_W'(SLOT_COUNT)) && !scan_end;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               priority if (op_type'(req_operation) == OP_REGISTER ||
                            op_type'(req_operation) == OP_SWEEP) begin
                  state_in = S_SCAN;
               end else if (op_type'(req_operation) == OP_LOOKUP && in_range) begin
                  state_in = S_LREAD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (scan_end) begin
               state_in = S_DONE;
            end
         end
         S_LREAD: state_in = S_LEVAL;
         S_LEVAL: state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      query_in      = query_ff;
      cnt_in        = cnt_ff;
      rd_pend_in    = issue;
      rd_idx_in     = cnt_ff[SLOT_W-1:0];
      have_free_in  = have_free_ff;
      free_idx_in   = free_idx_ff;
      gen_in        = gen_ff;
      valid_in      = valid_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_key_in    = res_key_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = rd_idx_ff;
      ram_wr_data   = {gen_ff, key_ff};
      ram_rd_en     = issue || (state_ff == S_LREAD);
      ram_rd_addr   = (state_ff == S_LREAD) ? query_ff : cnt_ff[SLOT_W-1:0];
      vld_rd_in     = ram_rd_en ? valid_ff[ram_rd_addr] : vld_rd_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_key_in    = rsp_key_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in         = op_type'(req_operation);
               key_in        = {req_vendor_id, req_product_id, req_bus_number,
                                req_port_address};
               query_in      = req_slot_query[SLOT_W-1:0];
               cnt_in        = '0;
               have_free_in  = 1'b0;
               res_slot_in   = '0;
               res_key_in    = '0;
               res_status_in = (op_type'(req_operation) == OP_LOOKUP && !in_range) ?
                               STATUS_NOT_FOUND : STATUS_OK;
            end
         end
         S_SCAN: begin
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (op_ff == OP_REGISTER) begin
               if (is_free) begin
                  have_free_in = 1'b1;
                  free_idx_in  = rd_idx_ff;
               end
               priority if (is_match) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = rd_idx_ff;
                  res_status_in = STATUS_OK;
                  res_slot_in   = rd_idx_ff;
                  res_key_in    = key_ff;
               end else if (last_rd && (have_free_ff || is_free)) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = is_free ? rd_idx_ff : free_idx_ff;
                  res_status_in = STATUS_OK;
                  res_slot_in   = ram_wr_addr;
                  res_key_in    = key_ff;
               end else if (last_rd) begin
                  res_status_in = STATUS_FULL;
                  res_slot_in   = '0;
                  res_key_in    = key_ff;
               end else begin
                  res_status_in = res_status_ff;
               end
               if (ram_wr_en) begin
                  valid_in[ram_wr_addr] = 1'b1;
               end
            end else begin
               // Stale entries are dropped by clearing their valid bit only.
               if (rd_pend_ff && (ent_data != '0) && (ent_tag != gen_ff)) begin
                  valid_in[rd_idx_ff] = 1'b0;
               end
               if (last_rd) begin
                  gen_in        = gen_ff + TAG_W'(1);
                  res_status_in = STATUS_OK;
                  res_slot_in   = '0;
                  res_key_in    = '0;
               end
            end
         end
         S_LREAD: begin
         end
         S_LEVAL: begin
            if (ent_key == '0) begin
               res_status_in = STATUS_NOT_FOUND;
               res_slot_in   = '0;
               res_key_in    = '0;
            end else begin
               res_status_in = STATUS_OK;
               res_slot_in   = query_ff;
               res_key_in    = ent_key;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = SLOT_OUT_W'(res_slot_ff);
               rsp_key_in    = res_key_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         have_free_ff <= 1'b0;
         gen_ff       <= GEN_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_pend_ff   <= rd_pend_in;
         have_free_ff <= have_free_in;
         gen_ff       <= gen_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      query_ff      <= query_in;
      rd_idx_ff     <= rd_idx_in;
      vld_rd_ff     <= vld_rd_in;
      free_idx_ff   <= free_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_key_ff    <= res_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_key_ff    <= rsp_key_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_number = rsp_slot_ff;
   assign rsp_device_key  = rsp_key_ff;

   // A new result is only ever loaded from the completion state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result appeared outside the completion state");

   // The generation moves only at the end of a sweep.
   a_gen_on_sweep: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (gen_ff != $past(gen_ff))) |->
         $past(state_ff == S_SCAN && op_ff == OP_SWEEP && last_rd))
      else $error("generation changed outside a sweep");

   // The scan counter never runs past the table.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(SLOT_COUNT))
      else $error("scan counter ran past the table");

   // The slot RAM is written only by a register transaction in its scan.
   a_wr_in_register: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_SCAN && op_ff == OP_REGISTER && rd_pend_ff))
      else $error("slot write outside a register scan");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the device alias table.
`timescale 1ns / 100ps

module tb;
   import dar_pkg::*;

   localparam int CYCLE_LIMIT      = 2_000_000;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int POOL_SIZE        = 40;
   localparam int RANDOM_STOP      = 1320;
   localparam int FILL_COUNT       = 260;

   typedef struct {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot_no;
      logic [KEY_W-1:0]      dev_key;
   } alias_reply_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [OP_W-1:0]       req_operation;
   logic [VID_W-1:0]      req_vendor_id;
   logic [PID_W-1:0]      req_product_id;
   logic [BUS_W-1:0]      req_bus_number;
   logic [PORT_W-1:0]     req_port_address;
   logic [QUERY_W-1:0]    req_slot_query;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_OUT_W-1:0] rsp_slot_number;
   logic [KEY_W-1:0]      rsp_device_key;

   // Predicted contents of the table and the current generation.
   logic [ENTRY_W-1:0] slot_image [SLOT_COUNT];
   logic [TAG_W-1:0]   cur_generation;

   alias_reply_type    expected_replies [$];
   alias_reply_type    head_reply;
   logic [KEY_W-1:0]   device_pool [POOL_SIZE];

   int  error_count;
   int  reply_count;
   int  items_sent;
   int  cycle_count;
   int  hold_count;
   int  req_gap_odds;
   int  rsp_stall_odds;
   bit  long_hold_req;

   device_alias_table u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_vendor_id    (req_vendor_id),
      .req_product_id   (req_product_id),
      .req_bus_number   (req_bus_number),
      .req_port_address (req_port_address),
      .req_slot_query   (req_slot_query),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot_number  (rsp_slot_number),
      .rsp_device_key   (rsp_device_key)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic alias_reply_type predict_alias_reply(
      op_type               op,
      logic [VID_W-1:0]     vid,
      logic [PID_W-1:0]     pid,
      logic [BUS_W-1:0]     bus,
      logic [PORT_W-1:0]    port,
      logic [QUERY_W-1:0]   query
   );
      alias_reply_type  reply;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] id;
      bit               have_free;
      bit               hit;
      int               free_idx;
      reply.status  = STATUS_OK;
      reply.slot_no = '0;
      reply.dev_key = '0;
      case (op)
         OP_REGISTER: begin
            key       = {vid, pid, bus, port};
            have_free = 1'b0;
            hit       = 1'b0;
            free_idx  = 0;
            // The first empty slot is only a candidate; a later slot holding the
            // same key still wins, which matters for the all-zero key.
            for (int i = 0; i < SLOT_COUNT && !hit; i++) begin
               id = slot_image[i][KEY_W-1:0];
               if (id == '0 && !have_free) begin
                  have_free = 1'b1;
                  free_idx  = i;
               end else if (id == key) begin
                  slot_image[i] = {cur_generation, id};
                  reply.slot_no = SLOT_OUT_W'(i);
                  hit           = 1'b1;
               end
            end
            reply.dev_key = key;
            if (!hit) begin
               if (have_free) begin
                  slot_image[free_idx] = {cur_generation, key};
                  reply.slot_no        = SLOT_OUT_W'(free_idx);
               end else begin
                  reply.status = STATUS_FULL;
               end
            end
         end
         OP_SWEEP: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (slot_image[i] != '0 && slot_image[i][ENTRY_W-1:KEY_W] != cur_generation)
                  slot_image[i] = '0;
            end
            cur_generation = cur_generation + 1'b1;
         end
         OP_LOOKUP: begin
            if (query >= SLOT_COUNT) begin
               reply.status = STATUS_NOT_FOUND;
            end else begin
               id = slot_image[query][KEY_W-1:0];
               if (id == '0) begin
                  reply.status = STATUS_NOT_FOUND;
               end else begin
                  reply.slot_no = query[SLOT_OUT_W-1:0];
                  reply.dev_key = id;
               end
            end
         end
         default: ;
      endcase
      return reply;
   endfunction

   task automatic send_txn(
      op_type               op,
      logic [VID_W-1:0]     vid,
      logic [PID_W-1:0]     pid,
      logic [BUS_W-1:0]     bus,
      logic [PORT_W-1:0]    port,
      logic [QUERY_W-1:0]   query
   );
      alias_reply_type want;
      int              gap;
      if (req_gap_odds > 0 && $urandom_range(1, 100) <= req_gap_odds) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_vendor_id    <= vid;
      req_product_id   <= pid;
      req_bus_number   <= bus;
      req_port_address <= port;
      req_slot_query   <= query;
      do @(posedge clock); while (req_stall);
      want = predict_alias_reply(op, vid, pid, bus, port, query);
      expected_replies.push_back(want);
      items_sent++;
   endtask

   task automatic register_key(logic [KEY_W-1:0] k);
      send_txn(OP_REGISTER, k[47:32], k[31:16], k[15:8], k[7:0], 16'($urandom));
   endtask

   task automatic lookup_slot(logic [QUERY_W-1:0] q);
      send_txn(OP_LOOKUP, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), q);
   endtask

   task automatic end_pass();
      send_txn(OP_SWEEP, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
               16'($urandom));
   endtask

   task automatic send_unused();
      send_txn(OP_NONE, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
               16'($urandom));
   endtask

   function automatic logic [KEY_W-1:0] random_key();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [QUERY_W-1:0] random_query();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return QUERY_W'($urandom_range(0, 63));
      else if (r < 90)
         return QUERY_W'($urandom_range(0, SLOT_COUNT - 1));
      return QUERY_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [KEY_W-1:0] fill_key(int i);
      return {16'hC000 | 16'(i), 16'(i * 37), 8'(i), 8'(~i)};
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH reply %0d %s: got %0h, expected %0h", reply_count, field, got, want);
      error_count++;
   endtask

   // Every accepted reply is checked against the oldest outstanding prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("unexpected reply",
                            64'({rsp_status, rsp_slot_number, rsp_device_key}), '0);
         end else begin
            head_reply = expected_replies.pop_front();
            if (rsp_status !== head_reply.status)
               report_mismatch("status", 64'(rsp_status), 64'(head_reply.status));
            if (rsp_slot_number !== head_reply.slot_no)
               report_mismatch("slot_number", 64'(rsp_slot_number), 64'(head_reply.slot_no));
            if (rsp_device_key !== head_reply.dev_key)
               report_mismatch("device_key", 64'(rsp_device_key), 64'(head_reply.dev_key));
         end
         reply_count++;
      end
   end

   // Receiver side: short random hold-offs, or one long hold when asked for.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            for (hold_count = 0; hold_count < LONG_HOLD_CYCLES; hold_count++)
               @(posedge clock);
            rsp_stall     <= 1'b0;
            long_hold_req = 1'b0;
         end else if (rsp_stall_odds > 0 && $urandom_range(1, 100) <= rsp_stall_odds) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   task automatic test_directed_cases();
      req_gap_odds   = 20;
      rsp_stall_odds = 15;
      lookup_slot(16'd0);
      lookup_slot(16'd255);
      lookup_slot(16'd256);
      lookup_slot(16'hFFFF);
      register_key({KEY_W{1'b1}});
      send_txn(OP_REGISTER, 16'h0001, 16'h0002, 8'h03, 8'h04, 16'h0000);
      register_key({KEY_W{1'b1}});
      // An all-zero key matches the empty slot after the first empty one.
      register_key('0);
      register_key('0);
      lookup_slot(16'd0);
      lookup_slot(16'd3);
      send_txn(OP_NONE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
      end_pass();
      send_txn(OP_REGISTER, 16'h0001, 16'h0002, 8'h03, 8'h04, 16'hFFFF);
      // Entries left on the previous generation, including the zero-key one, go now.
      end_pass();
      lookup_slot(16'd0);
      lookup_slot(16'd1);
      send_txn(OP_REGISTER, 16'h8000, 16'h0000, 8'h00, 8'h01, 16'h0000);
      send_txn(OP_REGISTER, 16'h0000, 16'h8000, 8'h80, 8'h80, 16'h0000);
      send_unused();
      lookup_slot(16'd2);
   endtask

   task automatic test_table_full();
      req_gap_odds   = 10;
      rsp_stall_odds = 10;
      for (int i = 0; i < FILL_COUNT; i++)
         register_key(fill_key(i));
      register_key('0);
      // The sweep frees only the slot still on the older generation, so the
      // zero key then finds one empty slot with nothing empty after it.
      end_pass();
      register_key('0);
      register_key('0);
      register_key(fill_key(5));
      register_key(random_key());
      register_key(random_key());
      lookup_slot(16'd1);
      lookup_slot(16'd255);
      lookup_slot(random_query());
      end_pass();
      end_pass();
   endtask

   task automatic test_enumeration_passes();
      int pass_no;
      int r;
      pass_no = 0;
      for (int i = 0; i < POOL_SIZE; i++)
         device_pool[i] = (i == 0) ? '0 : random_key();
      while (items_sent < RANDOM_STOP) begin
         if (pass_no % 4 == 3) begin
            req_gap_odds   = 0;
            rsp_stall_odds = 0;
         end else begin
            req_gap_odds   = $urandom_range(5, 30);
            rsp_stall_odds = $urandom_range(5, 30);
         end
         repeat ($urandom_range(10, 40)) begin
            r = $urandom_range(0, 99);
            if (r < 70)
               register_key(device_pool[$urandom_range(0, POOL_SIZE - 1)]);
            else if (r < 90)
               lookup_slot(random_query());
            else if (r < 95)
               send_unused();
            else if (r < 97)
               end_pass();
            else
               register_key(random_key());
         end
         end_pass();
         // Some devices are unplugged and others appear between passes.
         repeat ($urandom_range(0, 4))
            device_pool[$urandom_range(1, POOL_SIZE - 1)] = random_key();
         pass_no++;
      end
   endtask

   task automatic test_output_hold();
      req_gap_odds  = 0;
      long_hold_req = 1'b1;
      repeat (3) lookup_slot(random_query());
      register_key(device_pool[1]);
      repeat (3) lookup_slot(QUERY_W'($urandom_range(0, 31)));
      send_unused();
   endtask

   task automatic test_quiet_finish();
      int r;
      req_gap_odds   = 0;
      rsp_stall_odds = 0;
      repeat (60) begin
         r = $urandom_range(0, 99);
         if (r < 60)
            register_key(device_pool[$urandom_range(0, POOL_SIZE - 1)]);
         else if (r < 95)
            lookup_slot(random_query());
         else
            send_unused();
      end
      end_pass();
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (SLOT_COUNT + 8) @(posedge clock);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = '0;
      req_vendor_id    = '0;
      req_product_id   = '0;
      req_bus_number   = '0;
      req_port_address = '0;
      req_slot_query   = '0;
      long_hold_req    = 1'b0;
      req_gap_odds     = 0;
      rsp_stall_odds   = 0;
      error_count      = 0;
      reply_count      = 0;
      items_sent       = 0;
      cur_generation   = GEN_RESET;
      for (int i = 0; i < SLOT_COUNT; i++)
         slot_image[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_table_full();
      test_enumeration_passes();
      test_output_hold();
      test_quiet_finish();
      wait_drain();
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/dar_pkg.sv
hw/rtl/dar_ram.sv
hw/rtl/device_alias_table.sv
dv/tb.sv
